// ===== hw/rtl/jet_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Julia escape-time core.
// No dependencies.
package jet_pkg;

    localparam int FRAC_BITS    = 28;
    localparam int COORD_WIDTH  = 10;
    localparam int ITER_WIDTH   = 16;
    localparam int ZOOM_WIDTH   = 31;
    localparam int VALUE_WIDTH  = 32;
    localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;
    localparam int CFG_WIDTH    = 32;

    // Image size as a power of two (2 .. 1024, limited by the 10-bit pixel coordinates)
    localparam int IMAGE_COLUMNS_LOG2 = 10;
    localparam int IMAGE_ROWS_LOG2    = 10;
    localparam int IMAGE_COLUMNS      = 1 << IMAGE_COLUMNS_LOG2;
    localparam int IMAGE_ROWS         = 1 << IMAGE_ROWS_LOG2;

    localparam logic [PROD_WIDTH:0] ESCAPE_LIMIT = (PROD_WIDTH + 1)'(4) << (2 * FRAC_BITS);

    localparam logic [ZOOM_WIDTH-1:0]         ZOOM_RESET = ZOOM_WIDTH'(32'h1000_0000);
    localparam logic [ITER_WIDTH-1:0]         MAX_ITER_RESET = ITER_WIDTH'(100);

    typedef enum logic [1:0] {
        REG_ZOOM     = 2'd0,
        REG_C_REAL   = 2'd1,
        REG_C_IMAG   = 2'd2,
        REG_MAX_ITER = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] column;
        logic [COORD_WIDTH-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [ITER_WIDTH-1:0] iterations;
        logic                  bounded;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_LOAD,
        ST_MUL,
        ST_CHK
    } state_t;

    typedef struct packed {
        logic accept;
        logic map;
        logic load;
        logic mul;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

    function automatic logic signed [VALUE_WIDTH-1:0] sat32(input logic signed [PROD_WIDTH-1:0] v);
        logic signed [PROD_WIDTH-1:0] hi;
        logic signed [PROD_WIDTH-1:0] lo;
        hi = PROD_WIDTH'(signed'(33'sh0_7FFF_FFFF));
        lo = -hi - PROD_WIDTH'(1);
        if (v > hi)
            return VALUE_WIDTH'(hi);
        else if (v < lo)
            return VALUE_WIDTH'(lo);
        else
            return VALUE_WIDTH'(v);
    endfunction

    // (idx / 2^lg * 4 - 2) in Q4.28, saturated
    function automatic logic signed [VALUE_WIDTH-1:0] map_frac(
        input logic [COORD_WIDTH-1:0] idx,
        input int                     lg
    );
        logic signed [PROD_WIDTH-1:0] v;
        v = signed'((PROD_WIDTH'(idx) << (FRAC_BITS + 2 - lg))
                    - (PROD_WIDTH'(1) << (FRAC_BITS + 1)));
        return sat32(v);
    endfunction

endpackage

// ===== hw/rtl/julia_escape_time_pixel_core.sv =====
// Top level of the Julia escape-time pixel core: controller plus datapath.
// Depends on jet_pkg, jet_ctrl, jet_datapath.
//
// One pixel (column, row) per transaction; one result transaction (iteration count and
// bounded flag) per pixel. Arithmetic is Q4.28 with saturation. After a pixel is
// accepted, the mapped coordinates are scaled by zoom (MAP) and the start point is loaded
// (LOAD); then each iteration, at most max_iterations of them, and the final escape test
// take a square/product step (MUL) on three 32x32 multipliers and a test/update step
// (CHK), after which the result is registered. The last step waits while the output
// register still holds an unaccepted result. A new pixel is accepted the cycle after the
// previous one has moved to the output register. Configuration writes take effect
// immediately and are to be made only while the core is idle.
module julia_escape_time_pixel_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  jet_pkg::pixel_t                   pix,
    output logic                              res_valid,
    input  logic                              res_ready,
    output jet_pkg::result_t                  res,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [jet_pkg::CFG_WIDTH-1:0]     cfg_data
);
    import jet_pkg::*;

    cmd_t    cmd;
    status_t status;

    jet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .status    (status)
    );

    jet_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pix       (pix),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== hw/rtl/jet_datapath.sv =====
// Datapath: configuration registers, coordinate mapping, z iteration and result register.
// Depends on jet_pkg.
module jet_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jet_pkg::cmd_t                     cmd,
    output jet_pkg::status_t                  status,
    input  jet_pkg::pixel_t                   pix,
    output jet_pkg::result_t                  res,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [jet_pkg::CFG_WIDTH-1:0]     cfg_data
);
    import jet_pkg::*;

    logic [ZOOM_WIDTH-1:0]          zoom_reg;
    logic signed [VALUE_WIDTH-1:0]  c_real_reg;
    logic signed [VALUE_WIDTH-1:0]  c_imag_reg;
    logic [ITER_WIDTH-1:0]          max_iter_reg;

    logic signed [VALUE_WIDTH-1:0]  zx_reg, zx_next;
    logic signed [VALUE_WIDTH-1:0]  zy_reg, zy_next;
    logic signed [PROD_WIDTH-1:0]   sx_reg, sy_reg, pxy_reg;
    logic [ITER_WIDTH-1:0]          iter_reg;
    result_t                        res_reg;

    logic signed [VALUE_WIDTH-1:0]  zoom_s;
    logic signed [VALUE_WIDTH-1:0]  op_b0, op_b1;
    logic signed [PROD_WIDTH-1:0]   p0, p1, p2;
    logic signed [PROD_WIDTH-1:0]   diff;
    logic [PROD_WIDTH:0]            mag;
    logic signed [VALUE_WIDTH-1:0]  map_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg     <= ZOOM_RESET;
            c_real_reg   <= '0;
            c_imag_reg   <= '0;
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_ZOOM:     zoom_reg     <= cfg_data[ZOOM_WIDTH-1:0];
                REG_C_REAL:   c_real_reg   <= signed'(cfg_data[VALUE_WIDTH-1:0]);
                REG_C_IMAG:   c_imag_reg   <= signed'(cfg_data[VALUE_WIDTH-1:0]);
                REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    assign zoom_s = signed'({1'b0, zoom_reg});
    assign op_b0  = cmd.map ? zoom_s : zx_reg;
    assign op_b1  = cmd.map ? zoom_s : zy_reg;
    assign p0     = zx_reg * op_b0;
    assign p1     = zy_reg * op_b1;
    assign p2     = zx_reg * zy_reg;

    assign diff = sx_reg - sy_reg;
    assign mag  = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign status.done = (mag > ESCAPE_LIMIT) || (iter_reg >= max_iter_reg);

    assign map_y = sat32(sy_reg >>> FRAC_BITS);

    always_comb
    begin
        zx_next = zx_reg;
        zy_next = zy_reg;
        if (cmd.accept)
        begin
            zx_next = map_frac(pix.column, IMAGE_COLUMNS_LOG2);
            zy_next = map_frac(pix.row, IMAGE_ROWS_LOG2);
        end
        else if (cmd.load)
        begin
            zx_next = sat32(sx_reg >>> FRAC_BITS);
            zy_next = sat32(-PROD_WIDTH'(map_y));
        end
        else if (cmd.step)
        begin
            zx_next = sat32((diff >>> FRAC_BITS) + PROD_WIDTH'(c_real_reg));
            zy_next = sat32((pxy_reg >>> (FRAC_BITS - 1)) + PROD_WIDTH'(c_imag_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        zx_reg <= zx_next;
        zy_reg <= zy_next;
        if (cmd.map || cmd.mul)
        begin
            sx_reg  <= p0;
            sy_reg  <= p1;
            pxy_reg <= p2;
        end
        if (cmd.accept)
            iter_reg <= '0;
        else if (cmd.step)
            iter_reg <= iter_reg + ITER_WIDTH'(1);
        if (cmd.finish)
        begin
            res_reg.iterations <= iter_reg;
            res_reg.bounded    <= (iter_reg == max_iter_reg);
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/jet_ctrl.sv =====
// Controller: sequences mapping and iteration, owns the handshakes.
// Depends on jet_pkg.
module jet_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output jet_pkg::cmd_t     cmd,
    input  jet_pkg::status_t  status
);
    import jet_pkg::*;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   slot_free;

    assign slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pix_valid) state_next = ST_MAP;
            ST_MAP:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:  state_next = ST_CHK;
            ST_CHK:
            begin
                if (!status.done)
                    state_next = ST_MUL;
                else if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        pix_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pix_ready  = 1'b1;
                cmd.accept = pix_valid;
            end
            ST_MAP:  cmd.map  = 1'b1;
            ST_LOAD: cmd.load = 1'b1;
            ST_MUL:  cmd.mul  = 1'b1;
            ST_CHK:
            begin
                cmd.step   = !status.done;
                cmd.finish = status.done && slot_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.finish)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule
